// ----- rtl/fir_pkg.sv -----
// fir_pkg: shared types, widths and constants for the direct-form fir filter
// no dependencies; imported by every module under rtl
package fir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int COEF_COUNT   = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_TAPS_DEF = 8;
    localparam int ROUND_SHIFT  = 14;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    // stage control that travels along the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_flow;

    localparam t_coef   COEF_UNITY = 16'sd16384;
    localparam t_sample SAMPLE_MAX = 16'sh7fff;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

endpackage

// ----- rtl/fir_coef_bank.sv -----
// fir_coef_bank: coefficient register file written through the config port
// depends on fir_pkg
module fir_coef_bank (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fir_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output fir_pkg::t_coef                   o_coef [fir_pkg::COEF_COUNT]
);
    import fir_pkg::*;

    t_coef r_coef [COEF_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COEF_COUNT; k++) begin
                r_coef[k] <= '0;
            end
            r_coef[0] <= COEF_UNITY;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= t_coef'(i_cfg_data[COEF_W-1:0]);
        end
    end

    assign o_coef = r_coef;

endmodule

// ----- rtl/fir_tap_line.sv -----
// fir_tap_line: sample history and the registered tap window of one transaction
// depends on fir_pkg
module fir_tap_line #(
    parameter int NUM_TAPS = fir_pkg::NUM_TAPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  fir_pkg::t_sample  i_sample,
    input  logic              i_last,
    input  logic              i_rdy,
    output fir_pkg::t_flow    o_flow,
    output fir_pkg::t_sample  o_win [NUM_TAPS]
);
    import fir_pkg::*;

    t_flow   r_flow;
    t_sample r_win [NUM_TAPS];
    t_sample n_win [NUM_TAPS];
    logic    w_accept;

    assign w_accept = i_valid && i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow <= '0;
        end else if (i_rdy) begin
            r_flow.valid <= i_valid;
            r_flow.last  <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win <= n_win;
        end
    end

    generate
        if (NUM_TAPS > 1) begin : g_hist
            localparam int HistDepth = NUM_TAPS - 1;
            t_sample r_hist [HistDepth];

            always_comb begin
                n_win[0] = i_sample;
                for (int j = 1; j < NUM_TAPS; j++) begin
                    n_win[j] = r_hist[j-1];
                end
            end

            // history is cleared after the last sample of a block
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int k = 0; k < HistDepth; k++) begin
                        r_hist[k] <= '0;
                    end
                end else if (w_accept) begin
                    if (i_last) begin
                        for (int k = 0; k < HistDepth; k++) begin
                            r_hist[k] <= '0;
                        end
                    end else begin
                        r_hist[0] <= i_sample;
                        for (int k = 1; k < HistDepth; k++) begin
                            r_hist[k] <= r_hist[k-1];
                        end
                    end
                end
            end
        end else begin : g_no_hist
            always_comb begin
                n_win[0] = i_sample;
            end
        end
    endgenerate

    assign o_flow = r_flow;
    assign o_win  = r_win;

endmodule

// ----- rtl/fir_mac.sv -----
// fir_mac: registered tap products followed by a registered accumulation
// depends on fir_pkg
module fir_mac #(
    parameter int NUM_TAPS = fir_pkg::NUM_TAPS_DEF,
    parameter int ACC_W    = 2 * fir_pkg::SAMPLE_W + 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fir_pkg::t_flow           i_flow,
    input  fir_pkg::t_sample         i_win  [NUM_TAPS],
    input  fir_pkg::t_coef           i_coef [fir_pkg::COEF_COUNT],
    input  logic                     i_prod_rdy,
    input  logic                     i_sum_rdy,
    output fir_pkg::t_flow           o_prod_flow,
    output fir_pkg::t_flow           o_sum_flow,
    output logic signed [ACC_W-1:0]  o_acc
);
    import fir_pkg::*;

    localparam int ProdW = SAMPLE_W + COEF_W;

    t_flow                   r_prod_flow;
    t_flow                   r_sum_flow;
    logic signed [ProdW-1:0] r_prod [NUM_TAPS];
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    // product stage: one multiplier per tap, all in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_flow <= '0;
        end else if (i_prod_rdy) begin
            r_prod_flow <= i_flow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_prod_rdy && i_flow.valid) begin
            for (int j = 0; j < NUM_TAPS; j++) begin
                r_prod[j] <= ProdW'(i_win[j] * i_coef[j]);
            end
        end
    end

    // accumulate stage: exact sum of the products
    always_comb begin
        n_acc = '0;
        for (int j = 0; j < NUM_TAPS; j++) begin
            n_acc = n_acc + ACC_W'(r_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_flow <= '0;
        end else if (i_sum_rdy) begin
            r_sum_flow <= r_prod_flow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sum_rdy && r_prod_flow.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_prod_flow = r_prod_flow;
    assign o_sum_flow  = r_sum_flow;
    assign o_acc       = r_acc;

endmodule

// ----- rtl/fir_filter_direct_form_core.sv -----
// fir_filter_direct_form_core: top level of the direct-form fir filter
// depends on fir_pkg, fir_coef_bank, fir_tap_line and fir_mac
//
// Direct-form FIR with up to eight taps. Each accepted input transaction (a
// Q1.15 sample plus a last marker) yields exactly one output transaction: the
// sum of coef_j times the sample j steps back, rounded half up to Q1.15 and
// saturated. Samples before reset or before the start of a block count as
// zero; after a transaction marked last the history is cleared. One sample is
// taken every clock while o_stall is low, through a pipeline of tap window,
// parallel tap multipliers, accumulator and round/saturate output register.
// Each stage holds its transaction only while the stage after it is full and
// stalled, so an output stall first closes up the empty stages and, once all
// four are full, reaches o_stall in the same clock. Coefficients
// (Q2.14, indexes 0 to 7, coef_0 on the newest sample) are written through the
// config port while the filter is idle; at reset coef_0 is 1.0, the rest zero.
module fir_filter_direct_form_core #(
    parameter int NUM_TAPS = fir_pkg::NUM_TAPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [fir_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fir_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  fir_pkg::t_sample                 i_sample_in,
    input  logic                             i_last_in,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output fir_pkg::t_sample                 o_sample_out,
    output logic                             o_last_out
);
    import fir_pkg::*;

    // exact accumulator: full product width, growth for the taps, one spare bit
    localparam int AccW = SAMPLE_W + COEF_W + $clog2(NUM_TAPS) + 1;
    localparam int ShW  = AccW - ROUND_SHIFT;

    localparam logic signed [AccW-1:0] RoundBias = AccW'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [ShW-1:0]  SatHi     = ShW'(SAMPLE_MAX);
    localparam logic signed [ShW-1:0]  SatLo     = ShW'(SAMPLE_MIN);

    t_coef                  w_coef [COEF_COUNT];
    t_sample                w_win  [NUM_TAPS];
    t_flow                  w_tap_flow;
    t_flow                  w_prod_flow;
    t_flow                  w_sum_flow;
    logic signed [AccW-1:0] w_acc;

    // per-stage ready: a stage can load when it is empty or its data moves on
    logic w_rdy_out;
    logic w_rdy_sum;
    logic w_rdy_prod;
    logic w_rdy_tap;

    logic    r_out_valid;
    t_sample r_out_sample;
    logic    r_out_last;

    logic signed [AccW-1:0] w_biased;
    logic signed [ShW-1:0]  w_shifted;
    t_sample                n_out_sample;

    assign w_rdy_out  = !r_out_valid || !i_stall;
    assign w_rdy_sum  = !w_sum_flow.valid || w_rdy_out;
    assign w_rdy_prod = !w_prod_flow.valid || w_rdy_sum;
    assign w_rdy_tap  = !w_tap_flow.valid || w_rdy_prod;
    assign o_stall    = !w_rdy_tap;

    fir_coef_bank u_coef_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (w_coef)
    );

    fir_tap_line #(
        .NUM_TAPS (NUM_TAPS)
    ) u_tap_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_sample (i_sample_in),
        .i_last   (i_last_in),
        .i_rdy    (w_rdy_tap),
        .o_flow   (w_tap_flow),
        .o_win    (w_win)
    );

    fir_mac #(
        .NUM_TAPS (NUM_TAPS),
        .ACC_W    (AccW)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flow      (w_tap_flow),
        .i_win       (w_win),
        .i_coef      (w_coef),
        .i_prod_rdy  (w_rdy_prod),
        .i_sum_rdy   (w_rdy_sum),
        .o_prod_flow (w_prod_flow),
        .o_sum_flow  (w_sum_flow),
        .o_acc       (w_acc)
    );

    // round half toward plus infinity, then clamp to the q1.15 range
    always_comb begin
        w_biased  = w_acc + RoundBias;
        w_shifted = w_biased[AccW-1:ROUND_SHIFT];
        if (w_shifted > SatHi) begin
            n_out_sample = SAMPLE_MAX;
        end else if (w_shifted < SatLo) begin
            n_out_sample = SAMPLE_MIN;
        end else begin
            n_out_sample = t_sample'(w_shifted[SAMPLE_W-1:0]);
        end
    end

    // output register, holds while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_valid <= w_sum_flow.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out && w_sum_flow.valid) begin
            r_out_sample <= n_out_sample;
            r_out_last   <= w_sum_flow.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_last_out   = r_out_last;

    // a free-running consumer never backs the pipeline up
    a_no_stall_when_drained : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall
    ) else $error("input stalled while output side is not stalled");

    // an accepted transaction reaches the output when nothing stalls on the way
    a_latency : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_valid, 4) && !$past(o_stall, 4)
            && $past(i_rst_n, 4) && $past(i_rst_n, 3)
            && $past(i_rst_n, 2) && $past(i_rst_n, 1)
            && !$past(i_stall, 3) && !$past(i_stall, 2) && !$past(i_stall, 1))
        |-> o_valid
    ) else $error("transaction did not reach the output after four clocks");

    // the output register only fills from a valid accumulator stage
    a_out_from_sum : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_rdy_out && !w_sum_flow.valid) |=> !o_valid
    ) else $error("output valid without a transaction from the accumulator");

endmodule

// ----- tb/tb_fir_filter_direct_form_core.sv -----
// tb_fir_filter_direct_form_core: self-checking testbench for the direct-form fir filter core
// depends on fir_pkg and fir_filter_direct_form_core; needs no files or arguments
// a predictor tracks coefficients and tap history, and a monitor checks each output in order
module tb_fir_filter_direct_form_core;

    timeunit 1ns;
    timeprecision 1ps;

    import fir_pkg::*;

    localparam int TAPS         = NUM_TAPS_DEF;
    localparam int HIST_DEPTH   = 7;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    localparam t_coef COEF_MAX  = 16'sh7fff;
    localparam t_coef COEF_MIN  = 16'sh8000;
    localparam t_coef COEF_ZERO = 16'sd0;
    localparam t_coef COEF_LSB  = 16'sd1;

    // one filtered transaction as the output channel carries it
    typedef struct packed {
        t_sample sample;
        logic    last;
    } t_fir_output;

    // coefficient sets used between phases
    typedef enum int {
        PLAN_RANDOM,
        PLAN_ALL_MAX,
        PLAN_ALL_MIN,
        PLAN_AVERAGE,
        PLAN_SPARSE,
        PLAN_SMALL
    } t_coef_plan;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    t_sample                 i_sample_in;
    logic                    i_last_in;
    logic                    o_valid;
    logic                    i_stall;
    t_sample                 o_sample_out;
    logic                    o_last_out;

    // predictor state: coefficients as written and the past samples of the current block
    t_coef       coef_set [COEF_COUNT];
    t_coef       coef_plan [COEF_COUNT];
    t_sample     tap_hist [HIST_DEPTH];
    t_fir_output pending_outputs [$];

    // idling controls for the sender and the receiver process
    bit tx_idle_on;
    bit rx_idle_on;
    int hold_request;
    int stall_left;

    int mismatch_count;
    int samples_sent;
    int outputs_checked;
    int coef_writes;
    int input_stall_cycles;
    int cycle_count;

    fir_filter_direct_form_core #(
        .NUM_TAPS (TAPS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample_in  (i_sample_in),
        .i_last_in    (i_last_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // one accepted sample: exact sum of products, round half up, saturate,
    // then shift the history or clear it when the sample ends a block
    function automatic t_fir_output fir_step(t_sample x, logic last);
        t_fir_output res;
        longint      acc;
        longint      rounded;
        acc = longint'(coef_set[0]) * longint'(x);
        for (int j = 1; j < TAPS; j++) begin
            acc += longint'(coef_set[j]) * longint'(tap_hist[j-1]);
        end
        // arithmetic shift of a signed value is a floor
        rounded = (acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (rounded > longint'(SAMPLE_MAX)) begin
            rounded = longint'(SAMPLE_MAX);
        end else if (rounded < longint'(SAMPLE_MIN)) begin
            rounded = longint'(SAMPLE_MIN);
        end
        res.sample = t_sample'(rounded);
        res.last   = last;
        if (last) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                tap_hist[k] = '0;
            end
        end else begin
            for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                tap_hist[k] = tap_hist[k-1];
            end
            tap_hist[0] = x;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------

    // mostly no gap, some short ones, a few long ones
    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(3, 1);
        end else if (r < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // full range with extra weight on the rails and near zero
    function automatic t_sample rand_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return t_sample'(int'($urandom_range(64)) - 32);
            default: return t_sample'($urandom());
        endcase
    endfunction

    function automatic t_coef rand_coef();
        case ($urandom_range(7))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return COEF_ZERO;
            default: return t_coef'($urandom());
        endcase
    endfunction

    function automatic void fill_plan(t_coef_plan kind);
        for (int k = 0; k < COEF_COUNT; k++) begin
            case (kind)
                PLAN_RANDOM:  coef_plan[k] = rand_coef();
                PLAN_ALL_MAX: coef_plan[k] = COEF_MAX;
                PLAN_ALL_MIN: coef_plan[k] = COEF_MIN;
                PLAN_AVERAGE: coef_plan[k] = COEF_UNITY >>> 3;
                PLAN_SPARSE:  coef_plan[k] = ($urandom_range(2) == 0) ? rand_coef() : COEF_ZERO;
                default:      coef_plan[k] = t_coef'(int'($urandom_range(2048)) - 1024);
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------

    // writes all of coef_plan into the block, one register per clock;
    // only called while nothing is in flight
    task automatic apply_coefs();
        for (int k = 0; k < COEF_COUNT; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= k[CFG_IDX_W-1:0];
            i_cfg_data <= coef_plan[k];
            @(posedge i_clk);
            coef_set[k] = coef_plan[k];
            coef_writes++;
        end
        i_cfg_we   <= 1'b0;
        i_cfg_data <= CFG_DATA_W'($urandom());
    endtask

    // offers one transaction and holds it until the block takes it
    task automatic send_sample(t_sample x, logic last);
        int gap;
        i_valid     <= 1'b1;
        i_sample_in <= x;
        i_last_in   <= last;
        @(posedge i_clk);
        while (o_stall) begin
            input_stall_cycles++;
            @(posedge i_clk);
        end
        pending_outputs.push_back(fir_step(x, last));
        samples_sent++;
        gap = tx_idle_on ? rand_gap() : 0;
        if (gap > 0) begin
            // junk on the payload while valid is low must be ignored
            i_valid     <= 1'b0;
            i_sample_in <= t_sample'($urandom());
            i_last_in   <= 1'($urandom());
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender goes quiet until every expected output has come out
    task automatic drain_outputs();
        i_valid <= 1'b0;
        while (pending_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // named tests
    // ------------------------------------------------------------------

    // reset coefficients are unity on tap 0, so samples pass straight through
    task automatic test_reset_passthrough();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sh5555, 1'b1);
        drain_outputs();
    endtask

    // an impulse of one half walks out each coefficient in turn, coef_7 at its minimum
    task automatic test_impulse_response();
        for (int k = 0; k < COEF_COUNT; k++) begin
            coef_plan[k] = t_coef'((k % 2 == 0) ? (k + 1) * 1000 : -(k + 1) * 1000);
        end
        coef_plan[COEF_COUNT-1] = COEF_MIN;
        apply_coefs();
        send_sample(16'sh4000, 1'b0);
        for (int k = 1; k < TAPS; k++) begin
            send_sample(16'sd0, k == TAPS - 1);
        end
        drain_outputs();
    endtask

    // saturation both ways, and a last marker that must clear the history
    task automatic test_saturation();
        fill_plan(PLAN_ALL_MIN);
        apply_coefs();
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        // fresh block: minimum coefficient times maximum sample goes below range
        send_sample(SAMPLE_MAX, 1'b0);
        drain_outputs();
    endtask

    // coefficient of one lsb makes the rounding step visible, halves included
    task automatic test_rounding();
        fill_plan(PLAN_ALL_MIN);
        for (int k = 0; k < COEF_COUNT; k++) begin
            coef_plan[k] = COEF_ZERO;
        end
        coef_plan[0] = COEF_LSB;
        apply_coefs();
        send_sample(16'sd8192, 1'b0);
        send_sample(-16'sd8192, 1'b0);
        send_sample(16'sd8191, 1'b0);
        send_sample(-16'sd8193, 1'b0);
        send_sample(16'sd24576, 1'b0);
        send_sample(-16'sd24576, 1'b1);
        drain_outputs();
    endtask

    // blocks of random length under varied coefficient sets and idling
    task automatic test_random_blocks(t_coef_plan kind, int n_items, bit idling);
        int block_len;
        int pos;
        fill_plan(kind);
        apply_coefs();
        tx_idle_on = idling;
        rx_idle_on = idling;
        block_len  = $urandom_range(24, 1);
        pos        = 0;
        for (int n = 0; n < n_items; n++) begin
            pos++;
            // an odd stray last marker now and then breaks a block early
            if (pos >= block_len || $urandom_range(39) == 0) begin
                send_sample(rand_sample(), 1'b1);
                pos       = 0;
                block_len = ($urandom_range(9) == 0) ? $urandom_range(80, 25)
                                                    : $urandom_range(24, 1);
            end else begin
                send_sample(rand_sample(), 1'b0);
            end
            // sometimes the sender waits for everything in flight mid-phase
            if ($urandom_range(59) == 0) begin
                drain_outputs();
            end
        end
        drain_outputs();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the pipeline fills and the input stalls
    task automatic test_output_holdoff();
        fill_plan(PLAN_RANDOM);
        apply_coefs();
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = 200;
        for (int n = 0; n < 40; n++) begin
            send_sample(rand_sample(), n % 13 == 12);
        end
        drain_outputs();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall runs plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(3) == 0) begin
                stall_left = rand_gap();
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output checker: every accepted transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_fir_output want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected output, expected none, got sample %0d last %0b",
                         $time, o_sample_out, o_last_out);
                mismatch_count++;
            end else begin
                want = pending_outputs.pop_front();
                outputs_checked++;
                if (o_sample_out !== want.sample) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, want.sample, o_sample_out);
                    mismatch_count++;
                end
                if (o_last_out !== want.last) begin
                    $display("%0t: last_out mismatch, expected %0b, got %0b",
                             $time, want.last, o_last_out);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d outputs outstanding", $time, pending_outputs.size());
            $display("tb_fir_filter_direct_form_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_sample_in <= '0;
        i_last_in   <= 1'b0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_request = 0;
        // predictor starts from the reset state of the block
        for (int k = 0; k < COEF_COUNT; k++) begin
            coef_set[k] = COEF_ZERO;
        end
        coef_set[0] = COEF_UNITY;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            tap_hist[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_passthrough();
        test_impulse_response();
        test_saturation();
        test_rounding();
        test_random_blocks(PLAN_RANDOM, 90, 1'b0);
        test_random_blocks(PLAN_ALL_MAX, 90, 1'b1);
        test_output_holdoff();
        test_random_blocks(PLAN_SPARSE, 90, 1'b1);
        test_random_blocks(PLAN_ALL_MIN, 90, 1'b1);
        test_random_blocks(PLAN_AVERAGE, 90, 1'b1);
        test_random_blocks(PLAN_SMALL, 90, 1'b1);
        test_random_blocks(PLAN_RANDOM, 90, 1'b1);

        drain_outputs();
        if (pending_outputs.size() != 0) begin
            mismatch_count++;
        end
        $display("run covered %0d samples and %0d checked outputs over %0d coefficient writes,",
                 samples_sent, outputs_checked, coef_writes);
        $display("with %0d cycles of input backpressure and %0d mismatches",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb_fir_filter_direct_form_core: clean");
        end else begin
            $display("tb_fir_filter_direct_form_core: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fir_pkg.sv
rtl/fir_coef_bank.sv
rtl/fir_tap_line.sv
rtl/fir_mac.sv
rtl/fir_filter_direct_form_core.sv
tb/tb_fir_filter_direct_form_core.sv
